/* hdl/clcd_pkg.sv */
// shared types, codes and the power-on command table for the lcd write sequencer
package clcd_pkg;

   // request codes
   localparam logic [2:0] CMD_INIT  = 3'd0;
   localparam logic [2:0] CMD_BYTE  = 3'd1;
   localparam logic [2:0] CMD_CHAR  = 3'd2;
   localparam logic [2:0] CMD_CLEAR = 3'd3;
   localparam logic [2:0] CMD_GOTO  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_LINE0 = 2'd0;
   localparam logic [1:0] CSR_LINE1 = 2'd1;
   localparam logic [1:0] CSR_LINE2 = 2'd2;
   localparam logic [1:0] CSR_LINE3 = 2'd3;

   localparam logic [6:0] LINE0_RESET = 7'd0;
   localparam logic [6:0] LINE1_RESET = 7'd64;
   localparam logic [6:0] LINE2_RESET = 7'd20;
   localparam logic [6:0] LINE3_RESET = 7'd84;

   // lcd instruction bytes
   localparam logic [7:0] INSTR_CLEAR   = 8'h01;
   localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
   localparam logic [3:0] HOLD_NORMAL   = 4'd1;
   localparam logic [3:0] HOLD_CLEAR    = 4'd3;

   localparam int unsigned INIT_BYTES = 7;
   localparam logic [2:0] INIT_LAST_STEP = 3'(INIT_BYTES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POWER,
      ST_BYTE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       load_init;
      logic [2:0] init_step;
      logic       emit;
      logic       power;
      logic [1:0] phase;
      logic       last;
   } ctrl_cmd_type;

   // power-on command sequence
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0: b = 8'h33;
         3'd1: b = 8'h32;
         3'd2: b = 8'h28;
         3'd3: b = 8'h0E;
         3'd4: b = 8'h01;
         3'd5: b = 8'h06;
         3'd6: b = 8'h0C;
         default: b = 8'h0C;
      endcase
      return b;
   endfunction

endpackage

/* hdl/clcd_if.sv */
// request and phase channel interfaces
interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] value;
   logic [7:0] column;
   logic [2:0] row;

   modport source (output valid, command, value, column, row, input ready);
   modport sink (input valid, command, value, column, row, output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic       enable;
   logic [3:0] nibble;
   logic [3:0] hold_ms;
   logic       last;

   modport source (output valid, reg_select, enable, nibble, hold_ms, last, input ready);
   modport sink (input valid, reg_select, enable, nibble, hold_ms, last, output ready);
endinterface

/* hdl/char_lcd_4bit_write_sequencer.sv */
// top level of the 4-bit character lcd write sequencer
//
//   channel  direction  contents
//   req_if   in         command, value, column, row
//   rsp_if   out        reg_select, enable, nibble, hold_ms, last
//   csr_*    in         line base writes, index 0 to 3
//
// one request at a time, one phase per cycle while the phase channel takes them:
// a byte request is the transfer, then four phases; initialize is the transfer,
// the power-on wait phase, then twenty-eight phases. a request is taken in the
// cycle after the last phase is loaded; the state machine walks the phases and
// the single output register sets the pace. codes 5 to 7 are taken and dropped.
// a stalled phase holds the sequencer. synchronous active-high reset restores
// the line bases and empties the output.
module char_lcd_4bit_write_sequencer
   import clcd_pkg::*;
#(
   parameter int unsigned POWER_ON_WAIT_MS = 15
) (
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req_if,
   clcd_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);

   ctrl_cmd_type cmd;
   logic         out_free;

   // controller
   clcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_if.ready),
      .out_free    (out_free),
      .cmd         (cmd)
   );

   // datapath
   clcd_datapath #(
      .POWER_ON_WAIT_MS (POWER_ON_WAIT_MS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .out_free       (out_free),
      .req_command    (req_if.command),
      .req_value      (req_if.value),
      .req_column     (req_if.column),
      .req_row        (req_if.row),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_reg_select (rsp_if.reg_select),
      .rsp_enable     (rsp_if.enable),
      .rsp_nibble     (rsp_if.nibble),
      .rsp_hold_ms    (rsp_if.hold_ms),
      .rsp_last       (rsp_if.last)
   );

endmodule

/* hdl/clcd_ctrl.sv */
// sequencing state machine: walks the phases of one request
module clcd_ctrl
   import clcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [2:0]   req_command,
   output logic         req_ready,
   input  logic         out_free,
   output ctrl_cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] step_ff, step_in;
   logic       init_ff, init_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 2'd0;
         step_ff  <= 3'd0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         init_ff  <= init_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      init_in       = init_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.phase     = phase_ff;
      cmd.init_step = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               phase_in    = 2'd0;
               step_in     = 3'd0;
               init_in     = 1'b0;
               case (req_command)
                  CMD_INIT: state_in = ST_POWER;
                  CMD_BYTE, CMD_CHAR, CMD_CLEAR, CMD_GOTO: state_in = ST_BYTE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_POWER: begin
            if (out_free) begin
               cmd.emit      = 1'b1;
               cmd.power     = 1'b1;
               cmd.load_init = 1'b1;
               cmd.init_step = 3'd0;
               init_in       = 1'b1;
               step_in       = 3'd0;
               phase_in      = 2'd0;
               state_in      = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.last = (phase_ff == 2'd3) && (!init_ff || step_ff == INIT_LAST_STEP);
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd3) begin
                  if (init_ff && step_ff != INIT_LAST_STEP) begin
                     // next byte of the power-on sequence
                     step_in       = step_ff + 3'd1;
                     cmd.load_init = 1'b1;
                     cmd.init_step = step_ff + 3'd1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hdl/clcd_datapath.sv */
// byte register, line base registers and phase output register
module clcd_datapath
   import clcd_pkg::*;
#(
   parameter int unsigned POWER_ON_WAIT_MS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output logic         out_free,
   input  logic [2:0]   req_command,
   input  logic [7:0]   req_value,
   input  logic [7:0]   req_column,
   input  logic [2:0]   req_row,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_reg_select,
   output logic         rsp_enable,
   output logic [3:0]   rsp_nibble,
   output logic [3:0]   rsp_hold_ms,
   output logic         rsp_last
);

   localparam logic [3:0] HOLD_POWER = 4'(POWER_ON_WAIT_MS);

   logic [6:0] line_base_ff [4];
   logic [7:0] byte_ff, byte_in;
   logic       rs_ff, rs_in;
   logic [6:0] base_sel;
   logic [7:0] addr;

   logic       valid_ff;
   logic       rs_out_ff, en_out_ff, last_out_ff;
   logic [3:0] nib_out_ff, hold_out_ff;
   logic       en_in;
   logic [3:0] nib_in, hold_in;

   // line base registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_base_ff[0] <= LINE0_RESET;
         line_base_ff[1] <= LINE1_RESET;
         line_base_ff[2] <= LINE2_RESET;
         line_base_ff[3] <= LINE3_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE0: line_base_ff[0] <= csr_wdata;
            CSR_LINE1: line_base_ff[1] <= csr_wdata;
            CSR_LINE2: line_base_ff[2] <= csr_wdata;
            CSR_LINE3: line_base_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // go-to address, rows above three fall back to row zero
   assign base_sel = (req_row[2]) ? line_base_ff[0] : line_base_ff[req_row[1:0]];
   assign addr     = {1'b0, base_sel} + req_column;

   // byte to send and register select
   always_comb begin
      byte_in = byte_ff;
      rs_in   = rs_ff;
      if (cmd.capture) begin
         case (req_command)
            CMD_BYTE: begin
               byte_in = req_value;
               rs_in   = 1'b0;
            end
            CMD_CHAR: begin
               byte_in = req_value;
               rs_in   = 1'b1;
            end
            CMD_CLEAR: begin
               byte_in = INSTR_CLEAR;
               rs_in   = 1'b0;
            end
            CMD_GOTO: begin
               byte_in = LCD_SET_DDRAM | addr;
               rs_in   = 1'b0;
            end
            default: begin
               byte_in = byte_ff;
               rs_in   = 1'b0;
            end
         endcase
      end else if (cmd.load_init) begin
         byte_in = init_byte(cmd.init_step);
         rs_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
   end

   // phase pin values
   always_comb begin
      if (cmd.power) begin
         en_in   = 1'b0;
         nib_in  = 4'd0;
         hold_in = HOLD_POWER;
      end else begin
         en_in   = ~cmd.phase[0];
         nib_in  = cmd.phase[1] ? byte_ff[3:0] : byte_ff[7:4];
         hold_in = (cmd.phase == 2'd3 && !rs_ff && byte_ff == INSTR_CLEAR) ?
                   HOLD_CLEAR : HOLD_NORMAL;
      end
   end

   // output register, refilled on the cycle it is taken
   assign out_free = ~valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rs_out_ff   <= cmd.power ? 1'b0 : rs_ff;
         en_out_ff   <= en_in;
         nib_out_ff  <= nib_in;
         hold_out_ff <= hold_in;
         last_out_ff <= cmd.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = rs_out_ff;
   assign rsp_enable     = en_out_ff;
   assign rsp_nibble     = nib_out_ff;
   assign rsp_hold_ms    = hold_out_ff;
   assign rsp_last       = last_out_ff;

endmodule

/* test/char_lcd_4bit_write_sequencer_tb.sv */
// self-checking testbench for the 4-bit character lcd write sequencer
module char_lcd_4bit_write_sequencer_tb
   import clcd_pkg::*;
();

   localparam int unsigned POWER_WAIT    = 15;
   localparam int unsigned CLOCK_HALF    = 6;
   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned MAX_PRINTS    = 20;
   localparam int unsigned RUN_LIMIT     = 4_800_000;

   // request codes the block takes and drops
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] value;
      logic [7:0] column;
      logic [2:0] row;
   } lcd_request_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [3:0] nibble;
      logic [3:0] hold_ms;
      logic       last;
   } lcd_phase_type;

   // expands accepted requests into pin phases and checks the phase stream
   class lcd_phase_board;
      logic [6:0]     line_base [4];
      logic [7:0]     power_up_bytes [7];
      lcd_phase_type  batch [$];
      lcd_phase_type  pending_phases [$];
      int unsigned    errors;
      int unsigned    phases_seen;

      function new();
         line_base[0] = LINE0_RESET;
         line_base[1] = LINE1_RESET;
         line_base[2] = LINE2_RESET;
         line_base[3] = LINE3_RESET;
         power_up_bytes = '{8'h33, 8'h32, 8'h28, 8'h0E, INSTR_CLEAR, 8'h06, 8'h0C};
         errors = 0;
         phases_seen = 0;
      endfunction

      function void push_phase(logic rs, logic en, logic [3:0] nib, logic [3:0] hold);
         lcd_phase_type p;
         p.reg_select = rs;
         p.enable = en;
         p.nibble = nib;
         p.hold_ms = hold;
         p.last = 1'b0;
         batch.push_back(p);
      endfunction

      // high nibble then low nibble, each as enable high then enable low
      function void push_byte(logic rs, logic [7:0] b);
         logic [3:0] tail;
         tail = (!rs && b == INSTR_CLEAR) ? HOLD_CLEAR : HOLD_NORMAL;
         push_phase(rs, 1'b1, b[7:4], HOLD_NORMAL);
         push_phase(rs, 1'b0, b[7:4], HOLD_NORMAL);
         push_phase(rs, 1'b1, b[3:0], HOLD_NORMAL);
         push_phase(rs, 1'b0, b[3:0], tail);
      endfunction

      function void expand_request(lcd_request_type r);
         logic [6:0] base;
         batch.delete();
         case (r.command)
            CMD_INIT: begin
               push_phase(1'b0, 1'b0, 4'h0, 4'(POWER_WAIT));
               foreach (power_up_bytes[i]) push_byte(1'b0, power_up_bytes[i]);
            end
            CMD_BYTE: push_byte(1'b0, r.value);
            CMD_CHAR: push_byte(1'b1, r.value);
            CMD_CLEAR: push_byte(1'b0, INSTR_CLEAR);
            CMD_GOTO: begin
               // rows above 3 fall back to row 0
               base = (r.row <= 3'd3) ? line_base[r.row[1:0]] : line_base[0];
               push_byte(1'b0, LCD_SET_DDRAM | (r.column + 8'(base)));
            end
            default: ;
         endcase
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) pending_phases.push_back(batch[i]);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTS) $display("mismatch at phase %0d: %s", phases_seen, what);
      endtask

      task check_phase(lcd_phase_type got);
         lcd_phase_type want;
         phases_seen++;
         if (pending_phases.size() == 0) begin
            report($sformatf("unexpected phase %p", got));
            return;
         end
         want = pending_phases.pop_front();
         if (got.reg_select !== want.reg_select)
            report($sformatf("reg_select %b, want %b", got.reg_select, want.reg_select));
         if (got.enable !== want.enable)
            report($sformatf("enable %b, want %b", got.enable, want.enable));
         if (got.nibble !== want.nibble)
            report($sformatf("nibble %h, want %h", got.nibble, want.nibble));
         if (got.hold_ms !== want.hold_ms)
            report($sformatf("hold_ms %0d, want %0d", got.hold_ms, want.hold_ms));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;

   clcd_req_if req_if ();
   clcd_rsp_if rsp_if ();

   lcd_phase_board board = new();

   bit calm;
   bit start_hold;
   bit hold_rsp;

   char_lcd_4bit_write_sequencer #(
      .POWER_ON_WAIT_MS(POWER_WAIT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // observe transfers on both channels
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         board.expand_request('{command: req_if.command, value: req_if.value,
                                column: req_if.column, row: req_if.row});
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_phase('{reg_select: rsp_if.reg_select, enable: rsp_if.enable,
                             nibble: rsp_if.nibble, hold_ms: rsp_if.hold_ms,
                             last: rsp_if.last});
   end

   // long receiver hold-off, counted here
   initial begin
      hold_rsp = 1'b0;
      wait (start_hold);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // phase receiver with random stalls
   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            while (hold_rsp) @(posedge clock);
         end
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // offer one request and wait for its transfer
   task send_request(input lcd_request_type r);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= r.command;
      req_if.value <= r.value;
      req_if.column <= r.column;
      req_if.row <= r.row;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task send_fields(input logic [2:0] cmd, input logic [7:0] val,
                    input logic [7:0] col, input logic [2:0] row);
      send_request('{command: cmd, value: val, column: col, row: row});
   endtask

   // wait for every expected phase, then let the block settle
   task drain_phases();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_phases.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all four line bases, block idle
   task write_line_bases(input logic [6:0] b0, input logic [6:0] b1,
                         input logic [6:0] b2, input logic [6:0] b3);
      logic [6:0] vals [4];
      logic [1:0] idx [4];
      vals = '{b0, b1, b2, b3};
      idx = '{CSR_LINE0, CSR_LINE1, CSR_LINE2, CSR_LINE3};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.line_base[idx[i]] = vals[i];
      end
      csr_we <= 1'b0;
   endtask

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.value = ($urandom_range(0, 9) == 0) ? INSTR_CLEAR : 8'($urandom);
      r.column = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 39));
      r.row = 3'($urandom);
      if (pick < 4)
         r.command = CMD_INIT;
      else if (pick < 30)
         r.command = CMD_BYTE;
      else if (pick < 55)
         r.command = CMD_CHAR;
      else if (pick < 63)
         r.command = CMD_CLEAR;
      else if (pick < 95)
         r.command = CMD_GOTO;
      else
         r.command = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      return r;
   endfunction

   // random requests; dropped codes do not count
   task send_random(input int unsigned count);
      lcd_request_type r;
      int unsigned taken;
      taken = 0;
      while (taken < count) begin
         r = random_request();
         send_request(r);
         if (r.command <= CMD_GOTO) taken++;
      end
   endtask

   // stimulus
   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_LINE0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.command <= CMD_INIT;
      req_if.value <= '0;
      req_if.column <= '0;
      req_if.row <= '0;
      calm = 1'b0;
      start_hold = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the reset line bases
      send_fields(CMD_INIT, 8'h00, 8'h00, 3'd0);
      send_fields(CMD_BYTE, 8'h00, 8'hFF, 3'd7);
      send_fields(CMD_BYTE, 8'hFF, 8'h00, 3'd0);
      send_fields(CMD_BYTE, INSTR_CLEAR, 8'h00, 3'd0);
      send_fields(CMD_BYTE, LCD_SET_DDRAM, 8'h00, 3'd0);
      send_fields(CMD_CHAR, 8'h00, 8'h00, 3'd0);
      send_fields(CMD_CHAR, 8'hFF, 8'hFF, 3'd7);
      send_fields(CMD_CHAR, INSTR_CLEAR, 8'h00, 3'd0);
      send_fields(CMD_CLEAR, 8'hFF, 8'hFF, 3'd7);
      send_fields(CMD_GOTO, 8'hFF, 8'h00, 3'd0);
      send_fields(CMD_GOTO, 8'h00, 8'hFF, 3'd1);
      send_fields(CMD_GOTO, 8'h00, 8'h07, 3'd2);
      send_fields(CMD_GOTO, 8'h00, 8'h13, 3'd3);
      send_fields(CMD_GOTO, 8'h00, 8'h03, 3'd4);
      send_fields(CMD_GOTO, 8'h00, 8'h05, 3'd5);
      send_fields(CMD_GOTO, 8'h00, 8'h0A, 3'd6);
      send_fields(CMD_GOTO, 8'h00, 8'hFF, 3'd7);
      send_fields(CMD_FIRST_UNUSED, 8'h5A, 8'h00, 3'd0);
      send_fields(3'd6, 8'hA5, 8'h11, 3'd2);
      send_fields(CMD_LAST_UNUSED, 8'hFF, 8'hFF, 3'd7);
      drain_phases();

      // top of range, goto wraps the address
      write_line_bases(7'd127, 7'd127, 7'd127, 7'd127);
      send_fields(CMD_GOTO, 8'h00, 8'hFF, 3'd3);
      send_random(25);
      drain_phases();

      // bottom of range, back-to-back traffic
      write_line_bases(7'd0, 7'd0, 7'd0, 7'd0);
      calm = 1'b1;
      send_random(20);
      drain_phases();

      // random bases; receiver holds off while requests keep coming
      write_line_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
      calm = 1'b0;
      send_random(5);
      start_hold = 1'b1;
      calm = 1'b1;
      repeat (12) send_fields(CMD_CHAR, 8'($urandom), 8'h00, 3'd0);
      calm = 1'b0;
      send_random(8);
      drain_phases();

      // reset values written back explicitly
      write_line_bases(LINE0_RESET, LINE1_RESET, LINE2_RESET, LINE3_RESET);
      send_random(10);
      drain_phases();

      write_line_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
      send_random(10);
      drain_phases();

      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/clcd_pkg.sv
hdl/clcd_if.sv
hdl/clcd_ctrl.sv
hdl/clcd_datapath.sv
hdl/char_lcd_4bit_write_sequencer.sv
test/char_lcd_4bit_write_sequencer_tb.sv
